>>> src/tlcs_pkg.sv
// Package for the top-level comma splitter: character codes and result types.
// No dependencies; used by the interfaces, tlcs_scan, tlcs_fifo and the top level.
package tlcs_pkg;

    localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]
    localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;  // (
    localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;  // )
    localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;  // {
    localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;  // }
    localparam logic [7:0] CH_COMMA        = 8'h2C;
    localparam logic [7:0] CH_BACKSLASH    = 8'h5C;
    localparam logic [7:0] CH_DQUOTE       = 8'h22;
    localparam logic [7:0] CH_SQUOTE       = 8'h27;
    localparam logic [7:0] CH_SPACE        = 8'h20;
    localparam logic [7:0] CH_TAB          = 8'h09;
    localparam logic [7:0] CH_CR           = 8'h0D;
    localparam logic [7:0] CH_LF           = 8'h0A;
    localparam logic [7:0] NO_QUOTE        = 8'h00;

    localparam int FIELD_BITS = 16;

    typedef struct packed {
        logic [FIELD_BITS-1:0] part_offset;
        logic [FIELD_BITS-1:0] part_length;
        logic                  last_part;
    } part_t;

    // Up to two results per character, in order, count of valid entries.
    typedef struct packed {
        logic [1:0]      count;
        part_t [1:0]     part;
    } push_t;

endpackage

>>> src/tlcs_if.sv
// Valid/ready channel interfaces for the comma splitter.
// Depends on tlcs_pkg for field widths.
interface tlcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface tlcs_out_if;
    logic                            valid;
    logic                            ready;
    logic [tlcs_pkg::FIELD_BITS-1:0] part_offset;
    logic [tlcs_pkg::FIELD_BITS-1:0] part_length;
    logic                            last_part;

    modport source (output valid, output part_offset, output part_length,
                    output last_part, input ready);
    modport sink (input valid, input part_offset, input part_length,
                  input last_part, output ready);
endinterface

>>> src/tlcs_scan.sv
// Per-character scanner: nesting depths, quote tracking, trim bookkeeping.
// Produces zero, one or two results per accepted character. Depends on tlcs_pkg.
module tlcs_scan #(
    parameter longint unsigned MAX_TEXT_LEN = 65536,
    parameter int              DEPTH_BITS   = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      char_code,
    input  logic            end_of_text,
    output tlcs_pkg::push_t push
);

    localparam int POS_BITS = $clog2(MAX_TEXT_LEN);
    localparam int LEN_BITS = POS_BITS + 1;
    localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(MAX_TEXT_LEN - 1);
    localparam logic [LEN_BITS-1:0] TEXT_LEN = LEN_BITS'(MAX_TEXT_LEN);
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    typedef logic signed [DEPTH_BITS-1:0] depth_t;
    typedef logic [POS_BITS-1:0]          pos_t;

    depth_t     sq_reg, sq_next;
    depth_t     rd_reg, rd_next;
    depth_t     cu_reg, cu_next;
    logic [7:0] quote_reg, quote_next;
    logic       esc_reg, esc_next;
    pos_t       pos_reg, pos_next;
    pos_t       first_reg, first_next;
    pos_t       last_reg, last_next;
    logic       seen_reg, seen_next;

    pos_t       pos_inc;
    logic       split;
    logic       is_blank;

    function automatic depth_t depth_up(depth_t d);
        return (d == DEPTH_MAX) ? d : d + depth_t'(1);
    endfunction

    function automatic depth_t depth_down(depth_t d);
        return (d == DEPTH_MIN) ? d : d - depth_t'(1);
    endfunction

    function automatic tlcs_pkg::part_t make_part(logic seen, pos_t first, pos_t last,
                                                  pos_t past_end, logic final_part);
        tlcs_pkg::part_t     r;
        logic [LEN_BITS-1:0] span;
        // length = last - first + 1 modulo the text length
        span = {1'b0, last} - {1'b0, first} + LEN_BITS'(1);
        if (last < first)
        begin
            span = span + TEXT_LEN;
        end
        if (span == TEXT_LEN)
        begin
            span = '0;
        end
        r.last_part = final_part;
        if (seen)
        begin
            r.part_offset = tlcs_pkg::FIELD_BITS'(first);
            r.part_length = tlcs_pkg::FIELD_BITS'(span);
        end
        else
        begin
            r.part_offset = tlcs_pkg::FIELD_BITS'(past_end);
            r.part_length = '0;
        end
        return r;
    endfunction

    always_comb
    begin
        sq_next    = sq_reg;
        rd_next    = rd_reg;
        cu_next    = cu_reg;
        quote_next = quote_reg;
        esc_next   = esc_reg;
        first_next = first_reg;
        last_next  = last_reg;
        seen_next  = seen_reg;
        split      = 1'b0;
        pos_inc    = (pos_reg == POS_LAST) ? '0 : pos_reg + pos_t'(1);
        is_blank   = (char_code == tlcs_pkg::CH_SPACE) || (char_code == tlcs_pkg::CH_TAB) ||
                     (char_code == tlcs_pkg::CH_CR) || (char_code == tlcs_pkg::CH_LF);
        push       = '0;

        if (quote_reg != tlcs_pkg::NO_QUOTE)
        begin
            priority if (esc_reg)
            begin
                esc_next = 1'b0;
            end
            else if (char_code == tlcs_pkg::CH_BACKSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (char_code == quote_reg)
            begin
                quote_next = tlcs_pkg::NO_QUOTE;
            end
        end
        else
        begin
            unique case (char_code)
                tlcs_pkg::CH_DQUOTE, tlcs_pkg::CH_SQUOTE: quote_next = char_code;
                tlcs_pkg::CH_SQUARE_OPEN:  sq_next = depth_up(sq_reg);
                tlcs_pkg::CH_SQUARE_CLOSE: sq_next = depth_down(sq_reg);
                tlcs_pkg::CH_ROUND_OPEN:   rd_next = depth_up(rd_reg);
                tlcs_pkg::CH_ROUND_CLOSE:  rd_next = depth_down(rd_reg);
                tlcs_pkg::CH_CURLY_OPEN:   cu_next = depth_up(cu_reg);
                tlcs_pkg::CH_CURLY_CLOSE:  cu_next = depth_down(cu_reg);
                tlcs_pkg::CH_COMMA:
                    split = (sq_reg == '0) && (rd_reg == '0) && (cu_reg == '0);
                default: ;
            endcase
        end

        if (split)
        begin
            push.part[0] = make_part(seen_reg, first_reg, last_reg, pos_reg, 1'b0);
            push.count   = 2'd1;
            seen_next    = 1'b0;
            first_next   = '0;
            last_next    = '0;
        end
        else if (!is_blank)
        begin
            if (!seen_reg)
            begin
                first_next = pos_reg;
                seen_next  = 1'b1;
            end
            last_next = pos_reg;
        end

        pos_next = pos_inc;
        if (end_of_text)
        begin
            push.part[split] = make_part(seen_next, first_next, last_next, pos_inc, 1'b1);
            push.count       = split ? 2'd2 : 2'd1;
            sq_next    = '0;
            rd_next    = '0;
            cu_next    = '0;
            quote_next = tlcs_pkg::NO_QUOTE;
            esc_next   = 1'b0;
            pos_next   = '0;
            first_next = '0;
            last_next  = '0;
            seen_next  = 1'b0;
        end

        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg    <= '0;
            rd_reg    <= '0;
            cu_reg    <= '0;
            quote_reg <= tlcs_pkg::NO_QUOTE;
            esc_reg   <= 1'b0;
            pos_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            sq_reg    <= sq_next;
            rd_reg    <= rd_next;
            cu_reg    <= cu_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            pos_reg   <= pos_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            seen_reg  <= seen_next;
        end
    end

    // end of text returns the scanner to a clean start
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_text |=> pos_reg == '0 && !seen_reg && quote_reg == tlcs_pkg::NO_QUOTE)
        else $error("scanner state not cleared after end of text");

    // two results only when a splitting comma ends the text
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.part[1].last_part && !push.part[0].last_part)
        else $error("bad ordering of paired results");

    // nothing splits inside quotes
    a_no_split_quoted: assert property (@(posedge clk) disable iff (!rst_n)
        accept && quote_reg != tlcs_pkg::NO_QUOTE && !end_of_text |-> push.count == 2'd0)
        else $error("split inside a quoted span");

endmodule

>>> src/tlcs_fifo.sv
// Four-entry result buffer: takes up to two results per cycle given room, sends one on ready.
// Depends on tlcs_pkg and tlcs_out_if.
module tlcs_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  tlcs_pkg::push_t   push,
    output logic              room,
    tlcs_out_if.source        out_ch
);

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    tlcs_pkg::part_t         mem [DEPTH];
    logic [PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic                    pop;

    assign pop    = out_ch.valid && out_ch.ready;
    assign room   = count_reg <= CNT_BITS'(DEPTH - 2);

    assign out_ch.valid       = count_reg != '0;
    assign out_ch.part_offset = mem[rd_ptr_reg].part_offset;
    assign out_ch.part_length = mem[rd_ptr_reg].part_length;
    assign out_ch.last_part   = mem[rd_ptr_reg].last_part;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.part[0];
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_BITS'(1)] <= push.part[1];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= CNT_BITS'(DEPTH - 2))
        else $error("result buffer written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("result buffer count out of range");

    // a waiting output transaction is not withdrawn
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("output valid dropped while stalled");

endmodule

>>> src/top_level_comma_splitter_core.sv
// Top level of the comma splitter: scanner plus result buffer.
// Depends on tlcs_pkg, tlcs_if, tlcs_scan and tlcs_fifo.
//
// Takes one character per cycle and splits the text at commas that sit outside
// quotes and outside all brackets, reporting each trimmed part as offset and
// length. A character is accepted every clock while the four-entry result
// buffer has two free slots; characters that close no part or close one part
// keep that rate indefinitely while the consumer is ready. A comma that is
// also the final character makes two transactions on the output, which drain
// one per cycle while the consumer is ready, so the input stalls when two such
// pairs come close together, and while the consumer holds off. With the buffer
// empty, an accepted character's result is on the output in the next cycle.
module top_level_comma_splitter_core #(
    parameter longint unsigned MAX_TEXT_LEN = 65536,
    parameter int              DEPTH_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tlcs_in_if.sink     in_ch,
    tlcs_out_if.source  out_ch
);

    tlcs_pkg::push_t push;
    logic            room;
    logic            accept;

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    tlcs_scan #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN),
        .DEPTH_BITS   (DEPTH_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (in_ch.char_code),
        .end_of_text (in_ch.end_of_text),
        .push        (push)
    );

    tlcs_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule
